@@ hw/rtl/ffrp_pkg.sv @@
// ----------------------------------------------------------------------------
// ffrp_pkg: shared types and constants of the FASTA/FASTQ record parser
// Holds the transaction structs of both channels, the parse phase encoding,
// the file type and result kind codes, and the character constants.
// ----------------------------------------------------------------------------
package ffrp_pkg;

	// Widths fixed by the channel payloads.
	localparam int unsigned LABEL_OUT_W = 10;
	localparam int unsigned SEQ_OUT_W   = 32;
	localparam int unsigned KIND_W      = 3;

	// Characters the parser reacts to.
	localparam logic [7:0] CH_GT      = 8'h3E; // '>'
	localparam logic [7:0] CH_AT      = 8'h40; // '@'
	localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
	localparam logic [7:0] CH_NEWLINE = 8'h0A; // '\n'
	localparam logic [7:0] CH_SPACE   = 8'h20; // ' '

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_LABEL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SEQ   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd4;

	// Reset value of the label limit register.
	localparam logic [LABEL_OUT_W-1:0] MAX_LABEL_RESET = 10'd255;

	typedef enum logic [8:0] {
		PH_PRE_MARK   = 9'b0_0000_0001,
		PH_PRE_LABEL  = 9'b0_0000_0010,
		PH_LABEL      = 9'b0_0000_0100,
		PH_POST_LABEL = 9'b0_0000_1000,
		PH_SEQ        = 9'b0_0001_0000,
		PH_PLUS       = 9'b0_0010_0000,
		PH_QUAL       = 9'b0_0100_0000,
		PH_ERROR      = 9'b0_1000_0000,
		PH_DONE       = 9'b1_0000_0000
	} phase_t;

	typedef enum logic [1:0] {
		FT_UNKNOWN = 2'd0,
		FT_FASTA   = 2'd1,
		FT_FASTQ   = 2'd2
	} file_type_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [7:0]             byte_out;
		logic [LABEL_OUT_W-1:0] label_length;
		logic [SEQ_OUT_W-1:0]   sequence_length;
		logic                   is_fastq;
	} result_t;

endpackage

@@ hw/rtl/ffrp_parse.sv @@
// ----------------------------------------------------------------------------
// ffrp_parse: parse state and per-byte transition logic
// Holds the parse phase, file type, counters and record flag. For the byte
// presented it works out the result, if any, and commits the new state on step.
// ----------------------------------------------------------------------------
module ffrp_parse
	import ffrp_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 32,
	parameter int unsigned LABEL_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  item_t                  item,
	input  logic [LABEL_OUT_W-1:0] max_label_chars,
	output logic                   emit,
	output result_t                res
);

	localparam int unsigned LIM_W = (LABEL_BITS > LABEL_OUT_W) ? LABEL_BITS : LABEL_OUT_W;
	localparam logic [LIM_W-1:0] LABEL_MAX = LIM_W'({LABEL_BITS{1'b1}});

	phase_t                phase_q, phase_n;
	file_type_t            ftype_q, ftype_n;
	logic [LABEL_BITS-1:0] label_q, label_n;
	logic [COUNT_BITS-1:0] seq_q, seq_n;
	logic [COUNT_BITS-1:0] qual_q, qual_n;
	logic                  open_q, open_n;

	logic [LIM_W-1:0]       limit;
	logic [LABEL_OUT_W-1:0] label_len;
	logic [SEQ_OUT_W-1:0]   seq_len;

	// Effective label limit: the configured value clipped to the counter range.
	always_comb begin
		logic [LIM_W-1:0] cfg_ext;
		cfg_ext = LIM_W'(max_label_chars);
		limit   = (cfg_ext < LABEL_MAX) ? cfg_ext : LABEL_MAX;
	end

	generate
		if (LABEL_BITS >= LABEL_OUT_W) begin : g_lab_trunc
			assign label_len = label_q[LABEL_OUT_W-1:0];
		end else begin : g_lab_ext
			assign label_len = LABEL_OUT_W'(label_q);
		end
		if (COUNT_BITS > SEQ_OUT_W) begin : g_seq_sat
			assign seq_len = (|seq_q[COUNT_BITS-1:SEQ_OUT_W]) ? {SEQ_OUT_W{1'b1}}
				: seq_q[SEQ_OUT_W-1:0];
		end else begin : g_seq_ext
			assign seq_len = SEQ_OUT_W'(seq_q);
		end
	endgenerate

	always_comb begin
		logic [7:0] c;
		logic       do_label;
		logic       close_rec;
		logic       open_rec;
		c         = item.data_byte;
		do_label  = 1'b0;
		close_rec = 1'b0;
		open_rec  = 1'b0;
		phase_n   = phase_q;
		ftype_n   = ftype_q;
		label_n   = label_q;
		seq_n     = seq_q;
		qual_n    = qual_q;
		open_n    = open_q;
		emit      = 1'b0;
		res       = '0;
		res.is_fastq = (ftype_q == FT_FASTQ);

		if (phase_q == PH_ERROR || phase_q == PH_DONE) begin
			// Silent until reset.
		end else if (item.end_of_input) begin
			phase_n = PH_DONE;
			if (open_q) begin
				open_n    = 1'b0;
				close_rec = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_PRE_MARK: begin
					if (c == CH_GT || c == CH_AT) begin
						if (ftype_q == FT_UNKNOWN) begin
							ftype_n = (c == CH_GT) ? FT_FASTA : FT_FASTQ;
						end
						open_rec = 1'b1;
					end else if (c != CH_SPACE) begin
						phase_n  = PH_ERROR;
						open_n   = 1'b0;
						emit     = 1'b1;
						res.kind = KIND_ERROR;
					end
				end
				PH_PRE_LABEL: begin
					if (c == CH_NEWLINE) begin
						phase_n  = PH_SEQ;
						emit     = 1'b1;
						res.kind = KIND_EMPTY;
					end else if (c != CH_SPACE) begin
						phase_n  = PH_LABEL;
						do_label = 1'b1;
					end
				end
				PH_LABEL: begin
					do_label = 1'b1;
				end
				PH_POST_LABEL: begin
					if (c == CH_NEWLINE) begin
						phase_n = PH_SEQ;
					end
				end
				PH_SEQ: begin
					if (c == CH_SPACE || c == CH_NEWLINE) begin
						// skipped
					end else if (c == CH_GT && ftype_q == FT_FASTA) begin
						close_rec = 1'b1;
						open_rec  = 1'b1;
					end else if (c == CH_PLUS && ftype_q == FT_FASTQ) begin
						phase_n = PH_PLUS;
					end else begin
						if (!(&seq_q)) begin
							seq_n = seq_q + 1'b1;
						end
						emit         = 1'b1;
						res.kind     = KIND_SEQ;
						res.byte_out = c;
					end
				end
				PH_PLUS: begin
					if (c == CH_NEWLINE) begin
						phase_n = PH_QUAL;
					end
				end
				PH_QUAL: begin
					if (c == CH_NEWLINE) begin
						// skipped
					end else if (c == CH_AT && qual_q >= seq_q) begin
						close_rec = 1'b1;
						open_rec  = 1'b1;
					end else if (!(&qual_q)) begin
						qual_n = qual_q + 1'b1;
					end
				end
				default: begin
					phase_n = PH_ERROR;
				end
			endcase
		end

		if (do_label) begin
			if (c == CH_NEWLINE) begin
				phase_n = PH_SEQ;
			end else if (c == CH_SPACE && ftype_q == FT_FASTA) begin
				phase_n = PH_POST_LABEL;
			end else if (LIM_W'(label_q) < limit) begin
				label_n      = label_q + 1'b1;
				emit         = 1'b1;
				res.kind     = KIND_LABEL;
				res.byte_out = c;
			end
		end

		if (close_rec) begin
			emit                = 1'b1;
			res.kind            = KIND_END;
			res.label_length    = label_len;
			res.sequence_length = seq_len;
		end

		if (open_rec) begin
			phase_n = PH_PRE_LABEL;
			label_n = '0;
			seq_n   = '0;
			qual_n  = '0;
			open_n  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE_MARK;
			ftype_q <= FT_UNKNOWN;
			label_q <= '0;
			seq_q   <= '0;
			qual_q  <= '0;
			open_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			ftype_q <= ftype_n;
			label_q <= label_n;
			seq_q   <= seq_n;
			qual_q  <= qual_n;
			open_q  <= open_n;
		end
	end

endmodule

@@ hw/rtl/fasta_fastq_record_parser.sv @@
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser: streaming FASTA/FASTQ record parser
// Takes one file byte per transaction and gives label bytes, sequence bytes,
// record ends, empty header marks and a sticky parse error.
// ----------------------------------------------------------------------------
// Usage.
// The input channel (item_valid, item_stall, item) carries one file byte per
// transaction, or an end-of-input mark that closes any open record. The
// output channel (result_valid, result_stall, result) carries at most one
// result transaction for each input transaction, in input order. The label
// limit is written through the cfg_valid / cfg_ready / cfg_data channel,
// which is always ready; it should only be written while the parser is idle.
// A byte accepted from the input channel is held in the input register, and
// its result is loaded into the output register when the byte moves on.
// Throughput is one transaction per cycle while the receiver does not stall,
// set by the combinational transition of the parse state between the two
// registers. When the receiver stalls, the result waits in the output
// register; the byte in the input register keeps moving if it yields no
// result, otherwise item_stall is raised until the output register drains.
// Reset empties both registers, returns the parser to the state before the
// first record marker and loads the label limit with 255.
// ----------------------------------------------------------------------------
module fasta_fastq_record_parser
	import ffrp_pkg::*;
#(
	parameter int unsigned COUNT_BITS = 32,
	parameter int unsigned LABEL_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input byte channel.
	input  logic                   item_valid,
	output logic                   item_stall,
	input  item_t                  item,
	// Result channel.
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	// Label limit write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LABEL_OUT_W-1:0] cfg_data
);

	// Input register: one byte waiting for its transition.
	logic  item_valid_s1;
	item_t item_s1;

	// Output register.
	logic    result_valid_q;
	result_t result_q;

	logic [LABEL_OUT_W-1:0] max_label_q;

	logic    emit;
	result_t res;
	logic    advance;
	logic    item_accept;

	// The byte in the input register moves on unless it has a result and the
	// output register is full and being held by the receiver.
	assign advance     = item_valid_s1 && (!emit || !result_valid_q || !result_stall);
	assign item_stall  = item_valid_s1 && !advance;
	assign item_accept = item_valid && !item_stall;

	assign cfg_ready = 1'b1;

	ffrp_parse #(
		.COUNT_BITS (COUNT_BITS),
		.LABEL_BITS (LABEL_BITS)
	) u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.item            (item_s1),
		.max_label_chars (max_label_q),
		.emit            (emit),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1 <= item;
		end
	end

	// The output register can be refilled in the same cycle in which it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (advance && emit) || (result_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_label_q <= MAX_LABEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_label_q <= cfg_data;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ hw/rtl/ffrp_checker.sv @@
// ----------------------------------------------------------------------------
// ffrp_checker: port-level checks for the record parser
// Watches the result channel for a held transaction and for field values
// that do not belong to the kind of result shown.
// ----------------------------------------------------------------------------
module ffrp_checker
	import ffrp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_stall,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result
);

	// A stalled result stays valid and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	// The input side is only held back by a full output register that the
	// receiver is stalling.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled while the result channel was free");

	// Only the five defined result kinds appear.
	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.kind == KIND_LABEL || result.kind == KIND_SEQ
			|| result.kind == KIND_END || result.kind == KIND_ERROR
			|| result.kind == KIND_EMPTY))
		else $error("unknown result kind");

	// Only label and sequence results carry a byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_LABEL && result.kind != KIND_SEQ
		|-> result.byte_out == 8'h00)
		else $error("byte carried on a result without one");

	// Lengths are only reported on a record end.
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_END
		|-> result.label_length == '0 && result.sequence_length == '0)
		else $error("lengths carried on a result other than a record end");

endmodule

bind fasta_fastq_record_parser ffrp_checker u_ffrp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

@@ dv/fasta_fastq_record_parser_test.sv @@
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser_test: self-checking bench of the record parser
// Streams one FASTA or FASTQ file (type picked per run) through the parser:
// a short directed table first, then random records under several label
// limits. A predictor of the parse state works out the expected results the
// table leaves open; each result transaction is compared field by field with
// the oldest expectation. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fasta_fastq_record_parser_test;
	import ffrp_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 5;
	// The parser has two register stages; the drain wait covers them.
	localparam int DRAIN_CYCLES = 4;
	// About 1500 transactions, each at worst a full sender gap and a long run of
	// receiver stalls; the limit leaves a wide margin over that.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 200;
	localparam int NUM_PHASES   = 6;

	// One row of the directed table. Rows with typed set carry their
	// expectation directly; the others are left to the predictor.
	typedef struct packed {
		logic [7:0]        b;
		logic              mark;
		logic              typed;
		logic              has;
		logic [KIND_W-1:0] kind;
		logic [7:0]        bout;
	} dir_row_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	item_t                  item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [LABEL_OUT_W-1:0] cfg_data     = '0;

	// Predicted parse state, kept in step with every accepted transaction.
	phase_t                 p_phase;
	file_type_t             p_type;
	logic [LABEL_OUT_W-1:0] p_label_cnt;
	logic [SEQ_OUT_W-1:0]   p_seq_cnt;
	logic [SEQ_OUT_W-1:0]   p_qual_cnt;
	logic                   p_open;
	logic [LABEL_OUT_W-1:0] p_limit;

	result_t  pending_results[$];
	dir_row_t dir_table[$];
	int       failures    = 0;
	int       cycle_count = 0;
	int       items_sent  = 0;
	int       burst_left  = 0;
	int       stall_mode  = 0;
	int       stall_left  = 0;
	bit       fastq_run;
	logic [7:0] marker;
	string    bases = "ACGTN";

	fasta_fastq_record_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic result_t shaped(input logic [KIND_W-1:0] kind, input logic [7:0] b,
			input logic [LABEL_OUT_W-1:0] lab, input logic [SEQ_OUT_W-1:0] seq);
		result_t r;
		r.kind            = kind;
		r.byte_out        = b;
		r.label_length    = lab;
		r.sequence_length = seq;
		r.is_fastq        = (p_type == FT_FASTQ);
		return r;
	endfunction

	function automatic void start_record();
		p_phase     = PH_PRE_LABEL;
		p_label_cnt = '0;
		p_seq_cnt   = '0;
		p_qual_cnt  = '0;
		p_open      = 1'b1;
	endfunction

	// Advances the predicted state by one input transaction. Returns 1 and
	// fills r when the transaction gives a result.
	function automatic bit parse_step(input item_t it, output result_t r);
		logic [7:0] c;
		bit         in_label;
		c        = it.data_byte;
		in_label = 1'b0;
		r        = '0;
		// Both the sticky error and the end of input silence the parser.
		if (p_phase == PH_ERROR || p_phase == PH_DONE)
			return 1'b0;
		if (it.end_of_input) begin
			p_phase = PH_DONE;
			if (p_open) begin
				p_open = 1'b0;
				r = shaped(KIND_END, '0, p_label_cnt, p_seq_cnt);
				return 1'b1;
			end
			return 1'b0;
		end
		case (p_phase)
			PH_PRE_MARK: begin
				if (c == CH_GT || c == CH_AT) begin
					if (p_type == FT_UNKNOWN) begin
						if (c == CH_GT)
							p_type = FT_FASTA;
						else
							p_type = FT_FASTQ;
					end
					start_record();
					return 1'b0;
				end
				if (c == CH_SPACE)
					return 1'b0;
				p_phase = PH_ERROR;
				p_open  = 1'b0;
				r = shaped(KIND_ERROR, '0, '0, '0);
				return 1'b1;
			end
			PH_PRE_LABEL: begin
				if (c == CH_NEWLINE) begin
					p_phase = PH_SEQ;
					r = shaped(KIND_EMPTY, '0, '0, '0);
					return 1'b1;
				end
				if (c == CH_SPACE)
					return 1'b0;
				// Any other byte opens the label and is itself a label byte.
				p_phase  = PH_LABEL;
				in_label = 1'b1;
			end
			PH_LABEL: in_label = 1'b1;
			PH_POST_LABEL: begin
				if (c == CH_NEWLINE)
					p_phase = PH_SEQ;
				return 1'b0;
			end
			PH_SEQ: begin
				if (c == CH_SPACE || c == CH_NEWLINE)
					return 1'b0;
				if (c == CH_GT && p_type == FT_FASTA) begin
					r = shaped(KIND_END, '0, p_label_cnt, p_seq_cnt);
					start_record();
					return 1'b1;
				end
				if (c == CH_PLUS && p_type == FT_FASTQ) begin
					p_phase = PH_PLUS;
					return 1'b0;
				end
				if (p_seq_cnt != '1)
					p_seq_cnt++;
				r = shaped(KIND_SEQ, c, '0, '0);
				return 1'b1;
			end
			PH_PLUS: begin
				if (c == CH_NEWLINE)
					p_phase = PH_QUAL;
				return 1'b0;
			end
			PH_QUAL: begin
				if (c == CH_NEWLINE)
					return 1'b0;
				// An '@' ends the record only once the quality run is long enough.
				if (c == CH_AT && p_qual_cnt >= p_seq_cnt) begin
					r = shaped(KIND_END, '0, p_label_cnt, p_seq_cnt);
					start_record();
					return 1'b1;
				end
				if (p_qual_cnt != '1)
					p_qual_cnt++;
				return 1'b0;
			end
			default: begin
				p_phase = PH_ERROR;
				return 1'b0;
			end
		endcase
		if (in_label) begin
			if (c == CH_NEWLINE) begin
				p_phase = PH_SEQ;
			end else if (c == CH_SPACE && p_type == FT_FASTA) begin
				// In FASTA a space closes the label and the rest of the line is dropped.
				p_phase = PH_POST_LABEL;
			end else if (p_label_cnt < p_limit) begin
				p_label_cnt++;
				r = shaped(KIND_LABEL, c, '0, '0);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Presents one transaction and holds it until the parser takes it. The
	// sender works in bursts; a fresh burst may start after a random gap.
	task automatic put_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (item_stall);
		burst_left--;
	endtask

	task automatic feed(input logic [7:0] b, input logic eoi);
		item_t   it;
		result_t r;
		it.data_byte    = b;
		it.end_of_input = eoi;
		put_item(it);
		items_sent++;
		if (parse_step(it, r))
			pending_results.push_back(r);
	endtask

	// Stops sending and waits until every expected result has arrived and
	// the pipeline has had time to settle.
	task automatic wait_idle();
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LABEL_OUT_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		p_limit = v;
	endtask

	function automatic logic [7:0] label_char();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0:       b = CH_SPACE;
			1:       b = 8'($urandom_range(0, 255));
			default: b = 8'($urandom_range(33, 126));
		endcase
		if (b == CH_NEWLINE)
			b = CH_SPACE;
		return b;
	endfunction

	// Mostly bases; now and then any byte, and now and then a marker byte,
	// which FASTQ takes as an ordinary sequence byte.
	function automatic logic [7:0] seq_char(input bit broken);
		logic [7:0] b;
		if ($urandom_range(0, 29) == 0)
			b = $urandom_range(0, 1) ? CH_AT : CH_GT;
		else if ($urandom_range(0, 4) != 0)
			b = bases[$urandom_range(0, 4)];
		else
			b = 8'($urandom_range(0, 255));
		if (!broken && (fastq_run ? (b == CH_PLUS) : (b == CH_GT)))
			b = bases[4];
		return b;
	endfunction

	// Quality bytes are printable and may hold '@' early in the run.
	function automatic logic [7:0] qual_char();
		return 8'($urandom_range(33, 126));
	endfunction

	// One record with random content. A broken record carries stray bytes
	// and a quality run whose length may be wrong.
	task automatic gen_record(input bit broken);
		int n;
		int m;
		int i;
		// Close whatever record the stream is in, so that the marker below
		// really opens a new one. A short quality run is padded out unless
		// this record is to test an early marker.
		if (p_phase == PH_PRE_LABEL || p_phase == PH_LABEL || p_phase == PH_POST_LABEL)
			feed(CH_NEWLINE, 1'b0);
		if (fastq_run) begin
			if (p_phase == PH_SEQ)
				feed(CH_PLUS, 1'b0);
			if (p_phase == PH_PLUS)
				feed(CH_NEWLINE, 1'b0);
			while (!broken && p_phase == PH_QUAL && p_qual_cnt < p_seq_cnt)
				feed(qual_char(), 1'b0);
		end
		feed(marker, 1'b0);
		repeat ($urandom_range(0, 2)) feed(CH_SPACE, 1'b0);
		n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 48);
		repeat (n) feed(label_char(), 1'b0);
		feed(CH_NEWLINE, 1'b0);
		if (broken)
			repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)), 1'b0);
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 60);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				feed($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE, 1'b0);
			feed(seq_char(broken), 1'b0);
		end
		if (fastq_run) begin
			feed(CH_NEWLINE, 1'b0);
			feed(CH_PLUS, 1'b0);
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 8)) feed(8'($urandom_range(32, 126)), 1'b0);
			feed(CH_NEWLINE, 1'b0);
			m = broken ? n + int'($urandom_range(0, 6)) - 3 : n;
			for (i = 0; i < m; i++) begin
				if ($urandom_range(0, 19) == 0)
					feed(CH_NEWLINE, 1'b0);
				feed(qual_char(), 1'b0);
			end
		end
		if ($urandom_range(0, 1))
			feed(CH_NEWLINE, 1'b0);
	endtask

	task automatic add_row(input logic [7:0] b, input logic mark, input logic typed,
			input logic has, input logic [KIND_W-1:0] kind, input logic [7:0] bout);
		dir_row_t row;
		row.b     = b;
		row.mark  = mark;
		row.typed = typed;
		row.has   = has;
		row.kind  = kind;
		row.bout  = bout;
		dir_table.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Receiver side: checks every result transaction and drives the stall
	// pattern, which runs in stretches of no, light, heavy or near-total
	// stalling.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		int      pct;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: kind %0d byte %02h label %0d seq %0d fastq %0d",
						result.kind, result.byte_out, result.label_length,
						result.sequence_length, result.is_fastq);
			end else begin
				want = pending_results.pop_front();
				if (result.kind !== want.kind || result.byte_out !== want.byte_out ||
						result.label_length !== want.label_length ||
						result.sequence_length !== want.sequence_length ||
						result.is_fastq !== want.is_fastq) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: exp k%0d b%02h l%0d s%0d q%0d, got k%0d b%02h l%0d s%0d q%0d",
							want.kind, want.byte_out, want.label_length,
							want.sequence_length, want.is_fastq,
							result.kind, result.byte_out, result.label_length,
							result.sequence_length, result.is_fastq);
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
			0:       pct = 0;
			1:       pct = 25;
			2:       pct = 50;
			default: pct = 85;
		endcase
		result_stall <= ($urandom_range(0, 99) < pct);
	end

	// A hung handshake or a result that never arrives ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		item_t                  it;
		result_t                r;
		bit                     predicted;
		int                     ph;
		int                     start;
		logic [LABEL_OUT_W-1:0] lim;

		// The file type is latched once, so each run exercises one of them.
		fastq_run = 1'($urandom_range(0, 1));
		marker    = fastq_run ? CH_AT : CH_GT;

		p_phase     = PH_PRE_MARK;
		p_type      = FT_UNKNOWN;
		p_label_cnt = '0;
		p_seq_cnt   = '0;
		p_qual_cnt  = '0;
		p_open      = 1'b0;
		p_limit     = MAX_LABEL_RESET;

		// Leading space, marker, space after the marker, then an empty header.
		add_row(CH_SPACE,   1'b0, 1'b1, 1'b0, KIND_LABEL, 8'h00);
		add_row(8'h00,      1'b1, 1'b1, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_SPACE,   1'b0, 1'b1, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_NEWLINE, 1'b0, 1'b1, 1'b1, KIND_EMPTY, 8'h00);
		// Sequence bytes at both extremes, with a space and a newline skipped.
		add_row("A",        1'b0, 1'b1, 1'b1, KIND_SEQ,   "A");
		add_row(CH_SPACE,   1'b0, 1'b1, 1'b0, KIND_LABEL, 8'h00);
		add_row(8'hFF,      1'b0, 1'b1, 1'b1, KIND_SEQ,   8'hFF);
		add_row(8'h00,      1'b0, 1'b1, 1'b1, KIND_SEQ,   8'h00);
		add_row(CH_NEWLINE, 1'b0, 1'b1, 1'b0, KIND_LABEL, 8'h00);
		// Marker bytes inside the sequence, then a plus line and a quality
		// run holding an early '@'. The two file types part ways here.
		add_row(CH_GT,      1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_AT,      1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_NEWLINE, 1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_PLUS,    1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_NEWLINE, 1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row("!",        1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_AT,      1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row("!",        1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row("!",        1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row("!",        1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_NEWLINE, 1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		// Next record: label bytes at both extremes, then a space inside the
		// label, which only FASTA treats as the end of it.
		add_row(8'h00,      1'b1, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_SPACE,   1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(8'hFF,      1'b0, 1'b1, 1'b1, KIND_LABEL, 8'hFF);
		add_row(8'h00,      1'b0, 1'b1, 1'b1, KIND_LABEL, 8'h00);
		add_row(CH_SPACE,   1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row("z",        1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);
		add_row(CH_NEWLINE, 1'b0, 1'b0, 1'b0, KIND_LABEL, 8'h00);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			it.data_byte    = dir_table[i].mark ? marker : dir_table[i].b;
			it.end_of_input = 1'b0;
			put_item(it);
			// The predictor runs on every row to keep its state in step.
			predicted = parse_step(it, r);
			if (dir_table[i].typed) begin
				if (dir_table[i].has) begin
					r = '0;
					r.kind     = dir_table[i].kind;
					r.byte_out = dir_table[i].bout;
					r.is_fastq = fastq_run;
					pending_results.push_back(r);
				end
			end else if (predicted) begin
				pending_results.push_back(r);
			end
		end

		// Random records under a series of label limits, the extremes among
		// them. Each change waits for the parser to drain first.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       lim = 10'd1;
				1:       lim = 10'd1023;
				2:       lim = LABEL_OUT_W'($urandom_range(2, 12));
				3:       lim = LABEL_OUT_W'($urandom_range(13, 60));
				4:       lim = LABEL_OUT_W'($urandom_range(1, 1023));
				default: lim = LABEL_OUT_W'($urandom_range(20, 48));
			endcase
			write_limit(lim);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				gen_record($urandom_range(0, 6) == 0);
		end

		// End of input closes the open record; everything after it, a second
		// end of input included, must stay silent.
		feed(8'($urandom_range(0, 255)), 1'b1);
		feed("X", 1'b0);
		feed(marker, 1'b0);
		feed(8'($urandom_range(0, 255)), 1'b1);

		wait_idle();
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
